[src/word_cache_dm_or_4way_lru_macros.svh]
// Assertion macros shared by the word cache checker.
// No dependencies; every macro expects clk in scope, and all but WCACHE_ASSERT_ALWAYS_NEXT expect rst.
`ifndef WORD_CACHE_DM_OR_4WAY_LRU_MACROS_SVH
`define WORD_CACHE_DM_OR_4WAY_LRU_MACROS_SVH

// Same-cycle implication, checking off during reset
`define WCACHE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checking off during reset
`define WCACHE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define WCACHE_ASSERT_ALWAYS_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/wcache_pkg.sv]
// Shared constants, types and helpers for the word cache.
// No dependencies; used by every module of the block except wcache_ram.
package wcache_pkg;

  // Store geometry (MAX_SLOTS and SET_WAYS are powers of two)
  localparam int MAX_SLOTS   = 1024;
  localparam int SET_WAYS    = 4;
  localparam int SLOT_AW     = $clog2(MAX_SLOTS);
  localparam int WAY_W       = $clog2(SET_WAYS);

  // Field widths
  localparam int ADDR_W      = 32;
  localparam int WORD_W      = 32;
  localparam int TAG_W       = 30;
  localparam int STAMP_W     = 32;
  localparam int CNT_W       = 32;
  localparam int MODE_W      = 2;
  localparam int CFG_SLOTS_W = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int OUTCOME_W   = 2;
  localparam int WAY_OUT_W   = 2;

  // Width of a log2 slot count before and after clamping
  localparam int LOG_MAX = (SLOT_AW > CFG_SLOTS_W - 1) ? SLOT_AW : CFG_SLOTS_W - 1;
  localparam int LOG_W   = $clog2(LOG_MAX + 1);

  localparam int SLOTS_RESET = 1024;

  // Modes; any other code is pass-through
  localparam logic [MODE_W-1:0] MODE_DM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET = 2'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 2'd1;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_COLD = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_HOT  = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_PASS = 2'd3;

  // Per-slot bookkeeping held in the metadata RAM
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } meta_t;

  // Verdict of the shared way compare unit
  typedef struct packed {
    logic hit;
    logic empty;
    logic older;
  } probe_t;

  // log2 of the usable slot count: highest set bit, clamped to the store, zero -> 0
  function automatic logic [LOG_W-1:0] eff_log2(input logic [CFG_SLOTS_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < CFG_SLOTS_W; i++) begin
      if (v[i]) r = LOG_W'(i);
    end
    if (r > LOG_W'(SLOT_AW)) r = LOG_W'(SLOT_AW);
    return r;
  endfunction

endpackage

[src/wcache_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module wcache_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[src/wcache_cmp.sv]
// Shared way compare unit: tag match, empty slot and age compare for one way.
// Depends on wcache_pkg.
module wcache_cmp (
  input  wcache_pkg::meta_t                  entry,
  input  logic [wcache_pkg::TAG_W-1:0]       tag,
  input  logic [wcache_pkg::STAMP_W-1:0]     oldest,
  output wcache_pkg::probe_t                 result
);

  always_comb begin
    result.hit   = entry.valid && (entry.tag == tag);
    result.empty = !entry.valid;
    // strictly older than the best so far
    result.older = entry.stamp < oldest;
  end

endmodule

[src/word_cache_dm_or_4way_lru.sv]
// Word cache top level: sequencer, counters, slot RAMs and result register.
// Depends on wcache_pkg, wcache_ram and wcache_cmp.
//
// A lookup walks the ways of its set one at a time, a probe then a check
// state per way, through a single metadata RAM read port and one shared
// compare unit. A direct-mapped hit skips the write state; in four-way mode
// a hit or an empty slot stops the walk and a hot miss probes every way;
// pass-through goes straight to the done state. After reset the block
// clears all MAX_SLOTS (1024) metadata RAM entries and holds in_ready low
// meanwhile; configuration writes are taken at any time. A finished word
// waits in the output register while the next word is accepted.
module word_cache_dm_or_4way_lru (
  input  logic                                 clk,
  input  logic                                 rst,
  // lookup channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [wcache_pkg::ADDR_W-1:0]        address,
  input  logic [wcache_pkg::WORD_W-1:0]        memory_word,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wcache_pkg::WORD_W-1:0]        read_data,
  output logic [wcache_pkg::OUTCOME_W-1:0]     outcome,
  output logic [wcache_pkg::WAY_OUT_W-1:0]     way_used,
  output logic [wcache_pkg::CNT_W-1:0]         reference_count,
  output logic [wcache_pkg::CNT_W-1:0]         hit_count,
  output logic [wcache_pkg::CNT_W-1:0]         miss_count,
  output logic [wcache_pkg::CNT_W-1:0]         cold_miss_count,
  output logic [wcache_pkg::CNT_W-1:0]         hot_miss_count,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wcache_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcache_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [wcache_pkg::MODE_W-1:0]   mode;
  logic [wcache_pkg::LOG_W-1:0]    slots_log2;

  // current word
  logic [wcache_pkg::ADDR_W-1:0]   addr_q;
  logic [wcache_pkg::WORD_W-1:0]   mem_q;
  logic [wcache_pkg::WAY_W-1:0]    way_cnt;
  logic [wcache_pkg::WAY_W-1:0]    victim;
  logic [wcache_pkg::STAMP_W-1:0]  oldest;
  logic [wcache_pkg::STAMP_W-1:0]  wr_stamp;
  logic                            fill_word;
  logic [wcache_pkg::SLOT_AW-1:0]  clr_idx;

  // staged result
  logic [wcache_pkg::WORD_W-1:0]    res_data;
  logic [wcache_pkg::OUTCOME_W-1:0] res_outcome;
  logic [wcache_pkg::WAY_OUT_W-1:0] res_way;

  // statistics
  logic [wcache_pkg::CNT_W-1:0] lookups;
  logic [wcache_pkg::CNT_W-1:0] hits;
  logic [wcache_pkg::CNT_W-1:0] misses_total;
  logic [wcache_pkg::CNT_W-1:0] misses_cold_total;
  logic [wcache_pkg::CNT_W-1:0] misses_hot_total;

  // index and tag decode
  logic                            set_mode;
  logic [wcache_pkg::LOG_W-1:0]    way_log2;
  logic [wcache_pkg::LOG_W-1:0]    eff_wlog;
  logic [wcache_pkg::LOG_W-1:0]    shift;
  logic [wcache_pkg::SLOT_AW:0]    idx_one;
  logic [wcache_pkg::SLOT_AW-1:0]  idx_mask;
  logic [wcache_pkg::TAG_W-1:0]    word_addr;
  logic [wcache_pkg::TAG_W-1:0]    tag;
  logic [wcache_pkg::SLOT_AW-1:0]  idx;
  logic [wcache_pkg::SLOT_AW-1:0]  base;
  logic [wcache_pkg::WAY_W:0]      way_one;
  logic [wcache_pkg::WAY_W-1:0]    last_way;
  logic [wcache_pkg::WAY_W-1:0]    hot_victim;

  // RAM ports
  logic                                    meta_we;
  logic [wcache_pkg::SLOT_AW-1:0]          meta_waddr;
  wcache_pkg::meta_t                       meta_wdata;
  logic [wcache_pkg::SLOT_AW-1:0]          raddr;
  logic [$bits(wcache_pkg::meta_t)-1:0]    meta_rdata;
  wcache_pkg::meta_t                       meta_rd;
  logic                                    word_we;
  logic [wcache_pkg::WORD_W-1:0]           word_rd;
  wcache_pkg::probe_t                      probe;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // Ways per set: SET_WAYS, cut to the slot count; one way when direct mapped
  always_comb begin
    set_mode  = (mode == wcache_pkg::MODE_SET);
    way_log2  = (slots_log2 < wcache_pkg::LOG_W'(wcache_pkg::WAY_W)) ?
                slots_log2 : wcache_pkg::LOG_W'(wcache_pkg::WAY_W);
    eff_wlog  = set_mode ? way_log2 : '0;
    shift     = slots_log2 - eff_wlog;
    idx_one   = (wcache_pkg::SLOT_AW + 1)'(1) << shift;
    idx_mask  = wcache_pkg::SLOT_AW'(idx_one - 1'b1);
    word_addr = addr_q[wcache_pkg::ADDR_W-1:2];
    tag       = word_addr >> shift;
    idx       = word_addr[wcache_pkg::SLOT_AW-1:0] & idx_mask;
    base      = idx << eff_wlog;
    way_one   = (wcache_pkg::WAY_W + 1)'(1) << eff_wlog;
    last_way  = wcache_pkg::WAY_W'(way_one - 1'b1);
  end

  // Oldest-way tracking: a strictly older stamp takes over the victim
  assign hot_victim = (set_mode && probe.older) ? way_cnt : victim;

  // RAM addressing
  always_comb begin
    raddr      = base | wcache_pkg::SLOT_AW'(way_cnt);
    meta_we    = 1'b0;
    meta_waddr = base | wcache_pkg::SLOT_AW'(victim);
    meta_wdata = '{valid: 1'b1, tag: tag, stamp: wr_stamp};
    word_we    = (state == ST_WRITE) && fill_word;
    if (state == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_idx;
      meta_wdata = '0;
    end else if (state == ST_WRITE) begin
      meta_we = 1'b1;
    end
  end

  assign meta_rd = wcache_pkg::meta_t'(meta_rdata);

  wcache_ram #(
    .WIDTH($bits(wcache_pkg::meta_t)),
    .DEPTH(wcache_pkg::MAX_SLOTS)
  ) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wdata),
    .raddr(raddr),
    .rdata(meta_rdata)
  );

  wcache_ram #(
    .WIDTH(wcache_pkg::WORD_W),
    .DEPTH(wcache_pkg::MAX_SLOTS)
  ) u_word_ram (
    .clk  (clk),
    .we   (word_we),
    .waddr(meta_waddr),
    .wdata(mem_q),
    .raddr(raddr),
    .rdata(word_rd)
  );

  wcache_cmp u_cmp (
    .entry (meta_rd),
    .tag   (tag),
    .oldest(oldest),
    .result(probe)
  );

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_idx           <= '0;
      mode              <= wcache_pkg::MODE_DM;
      slots_log2        <= wcache_pkg::eff_log2(
                             wcache_pkg::CFG_SLOTS_W'(wcache_pkg::SLOTS_RESET));
      out_valid         <= 1'b0;
      lookups           <= '0;
      hits              <= '0;
      misses_total      <= '0;
      misses_cold_total <= '0;
      misses_hot_total  <= '0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wcache_pkg::CFG_MODE:  mode       <= cfg_data[wcache_pkg::MODE_W-1:0];
          wcache_pkg::CFG_SLOTS: slots_log2 <= wcache_pkg::eff_log2(
                                   cfg_data[wcache_pkg::CFG_SLOTS_W-1:0]);
          default: ;
        endcase
      end

      // taken word leaves; a finishing lookup reloads the register below
      if (out_ready && state != ST_DONE) out_valid <= 1'b0;

      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == wcache_pkg::SLOT_AW'(wcache_pkg::MAX_SLOTS - 1)) state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (in_valid) begin
            addr_q  <= address;
            mem_q   <= memory_word;
            way_cnt <= '0;
            victim  <= '0;
            oldest  <= lookups + 1'b1;
            if (mode == wcache_pkg::MODE_DM || mode == wcache_pkg::MODE_SET) begin
              lookups <= lookups + 1'b1;
              state   <= ST_PROBE;
            end else begin
              res_data    <= memory_word;
              res_outcome <= wcache_pkg::OUT_PASS;
              res_way     <= '0;
              state       <= ST_DONE;
            end
          end
        end

        // RAM read of way_cnt in flight
        ST_PROBE: state <= ST_CHECK;

        ST_CHECK: begin
          if (probe.hit) begin
            hits        <= hits + 1'b1;
            res_data    <= word_rd;
            res_outcome <= wcache_pkg::OUT_HIT;
            res_way     <= wcache_pkg::WAY_OUT_W'(way_cnt);
            victim      <= way_cnt;
            wr_stamp    <= lookups;
            fill_word   <= 1'b0;
            // only set mode refreshes the stamp
            state       <= set_mode ? ST_WRITE : ST_DONE;
          end else if (probe.empty) begin
            misses_total      <= misses_total + 1'b1;
            misses_cold_total <= misses_cold_total + 1'b1;
            res_data          <= mem_q;
            res_outcome       <= wcache_pkg::OUT_COLD;
            res_way           <= wcache_pkg::WAY_OUT_W'(way_cnt);
            victim            <= way_cnt;
            wr_stamp          <= set_mode ? lookups : meta_rd.stamp;
            fill_word         <= 1'b1;
            state             <= ST_WRITE;
          end else if (way_cnt == last_way) begin
            misses_total     <= misses_total + 1'b1;
            misses_hot_total <= misses_hot_total + 1'b1;
            res_data         <= mem_q;
            res_outcome      <= wcache_pkg::OUT_HOT;
            res_way          <= wcache_pkg::WAY_OUT_W'(hot_victim);
            victim           <= hot_victim;
            // direct mapped keeps the slot's old stamp
            wr_stamp         <= set_mode ? lookups : meta_rd.stamp;
            fill_word        <= 1'b1;
            state            <= ST_WRITE;
          end else begin
            if (set_mode && probe.older) oldest <= meta_rd.stamp;
            victim  <= hot_victim;
            way_cnt <= way_cnt + 1'b1;
            state   <= ST_PROBE;
          end
        end

        ST_WRITE: state <= ST_DONE;

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            read_data       <= res_data;
            outcome         <= res_outcome;
            way_used        <= res_way;
            reference_count <= lookups;
            hit_count       <= hits;
            miss_count      <= misses_total;
            cold_miss_count <= misses_cold_total;
            hot_miss_count  <= misses_hot_total;
            state           <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/wcache_chk.sv]
// Port-level checker for the word cache, bound to the top level.
// Depends on wcache_pkg and word_cache_dm_or_4way_lru_macros.svh.
`include "word_cache_dm_or_4way_lru_macros.svh"

module wcache_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [wcache_pkg::WORD_W-1:0]        read_data,
  input logic [wcache_pkg::OUTCOME_W-1:0]     outcome,
  input logic [wcache_pkg::WAY_OUT_W-1:0]     way_used,
  input logic [wcache_pkg::CNT_W-1:0]         reference_count,
  input logic [wcache_pkg::CNT_W-1:0]         hit_count,
  input logic [wcache_pkg::CNT_W-1:0]         miss_count,
  input logic [wcache_pkg::CNT_W-1:0]         cold_miss_count,
  input logic [wcache_pkg::CNT_W-1:0]         hot_miss_count
);

  logic [wcache_pkg::CNT_W-1:0] hit_plus_miss;
  logic [wcache_pkg::CNT_W-1:0] cold_plus_hot;

  assign hit_plus_miss = hit_count + miss_count;
  assign cold_plus_hot = cold_miss_count + hot_miss_count;

  // every counted lookup is a hit or a miss
  `WCACHE_ASSERT_NOW(a_lookup_split, out_valid, reference_count == hit_plus_miss, "lookups != hits + misses")

  // every miss is cold or hot
  `WCACHE_ASSERT_NOW(a_miss_split, out_valid, miss_count == cold_plus_hot, "misses != cold + hot")

  // uncached words report way zero
  `WCACHE_ASSERT_NOW(a_pass_way, out_valid && outcome == wcache_pkg::OUT_PASS, way_used == '0, "pass-through with nonzero way")

  // clearing pass follows reset
  `WCACHE_ASSERT_ALWAYS_NEXT(a_clear_after_rst, rst, !in_ready, "input ready right after reset")

  // stalled word holds
  `WCACHE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data), "stalled word dropped or changed")

endmodule

bind word_cache_dm_or_4way_lru wcache_chk u_wcache_chk (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .read_data      (read_data),
  .outcome        (outcome),
  .way_used       (way_used),
  .reference_count(reference_count),
  .hit_count      (hit_count),
  .miss_count     (miss_count),
  .cold_miss_count(cold_miss_count),
  .hot_miss_count (hot_miss_count)
);

[tb/word_cache_dm_or_4way_lru_tb.sv]
// Testbench for word_cache_dm_or_4way_lru: directed table then random phases,
// every result word checked against an in-bench cache predictor or a hand-written expected result.
// Depends on wcache_pkg and the word_cache_dm_or_4way_lru top level.
`timescale 1ns / 100ps

module tb;
  import wcache_pkg::*;

  // Pass-through mode codes (the package names only the caching modes)
  localparam logic [MODE_W-1:0] MODE_PASS     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PASS_ALT = 2'd3;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_WORDS   = 1300;

  typedef struct packed {
    logic [WORD_W-1:0]    data;
    logic [OUTCOME_W-1:0] outcome;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     refs;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     colds;
    logic [CNT_W-1:0]     hots;
  } lookup_result_t;

  typedef enum logic {ROW_CFG, ROW_LOOKUP} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    logic [ADDR_W-1:0]      addr;
    logic [WORD_W-1:0]      word;
    bit                     known;
    lookup_result_t         result;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [ADDR_W-1:0]     address;
  logic [WORD_W-1:0]     memory_word;
  logic                  out_valid;
  logic                  out_ready;
  logic [WORD_W-1:0]     read_data;
  logic [OUTCOME_W-1:0]  outcome;
  logic [WAY_OUT_W-1:0]  way_used;
  logic [CNT_W-1:0]      reference_count;
  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;
  logic [CNT_W-1:0]      cold_miss_count;
  logic [CNT_W-1:0]      hot_miss_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  word_cache_dm_or_4way_lru uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .address         (address),
    .memory_word     (memory_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .outcome         (outcome),
    .way_used        (way_used),
    .reference_count (reference_count),
    .hit_count       (hit_count),
    .miss_count      (miss_count),
    .cold_miss_count (cold_miss_count),
    .hot_miss_count  (hot_miss_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Shadow copy of the cache contents and settings
  bit                   shadow_valid [MAX_SLOTS];
  logic [TAG_W-1:0]     shadow_tag   [MAX_SLOTS];
  logic [WORD_W-1:0]    shadow_word  [MAX_SLOTS];
  logic [STAMP_W-1:0]   shadow_stamp [MAX_SLOTS];
  logic [CNT_W-1:0]     n_refs, n_hits, n_misses, n_cold, n_hot;
  logic [MODE_W-1:0]    cur_mode  = MODE_DM;
  logic [CFG_SLOTS_W-1:0] cur_slots = CFG_SLOTS_W'(SLOTS_RESET);

  lookup_result_t lookup_results_due[$];
  lookup_result_t oldest_due;
  stim_row_t      directed_rows[$];
  int             mismatches  = 0;
  int             words_sent  = 0;
  int             burst_left  = 0;
  int             idle_cycles = 0;

  // Receiver stall pattern state
  int rx_style      = 0;
  int rx_style_left = 0;
  int rx_run_left   = 0;
  bit rx_stalled    = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Usable slot count: clamp to the store, round down to a power of two, zero -> one
  function automatic int usable_slots(input logic [CFG_SLOTS_W-1:0] v);
    int lim, p;
    lim = (v > MAX_SLOTS) ? MAX_SLOTS : int'(v);
    p = 1;
    while (p * 2 <= lim) p = p * 2;
    return p;
  endfunction

  function automatic int log2_exact(input int n);
    int b;
    b = 0;
    while ((1 << b) < n) b++;
    return b;
  endfunction

  // Predict one lookup and update the shadow cache
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr,
                                                     input logic [WORD_W-1:0] mem);
    lookup_result_t r;
    int s, ways, sets, base, victim, k;
    logic [31:0] idx, tag, oldest;
    bit done, cold;
    r = '0;
    r.data = mem;
    r.outcome = OUT_PASS;
    s = usable_slots(cur_slots);
    if (cur_mode == MODE_DM) begin
      idx = (addr >> 2) & (s - 1);
      tag = addr >> (log2_exact(s) + 2);
      n_refs++;
      if (shadow_valid[idx] && shadow_tag[idx] == tag[TAG_W-1:0]) begin
        n_hits++;
        r.data = shadow_word[idx];
        r.outcome = OUT_HIT;
      end else begin
        n_misses++;
        if (!shadow_valid[idx]) begin
          n_cold++;
          r.outcome = OUT_COLD;
        end else begin
          n_hot++;
          r.outcome = OUT_HOT;
        end
        shadow_valid[idx] = 1'b1;
        shadow_tag[idx]   = tag[TAG_W-1:0];
        shadow_word[idx]  = mem;
      end
    end else if (cur_mode == MODE_SET) begin
      ways = (SET_WAYS > s) ? s : SET_WAYS;
      sets = s / ways;
      idx  = (addr >> 2) & (sets - 1);
      tag  = addr >> (log2_exact(sets) + 2);
      base = idx * ways;
      n_refs++;
      oldest = n_refs;
      victim = 0;
      done   = 0;
      cold   = 0;
      // walk the set: a hit or an empty way stops, else track strictly-oldest stamp
      for (int i = 0; i < ways; i++) begin
        k = base + i;
        if (!done) begin
          if (shadow_valid[k] && shadow_tag[k] == tag[TAG_W-1:0]) begin
            n_hits++;
            r.data = shadow_word[k];
            shadow_stamp[k] = n_refs;
            r.outcome = OUT_HIT;
            victim = i;
            done = 1;
          end else if (!shadow_valid[k]) begin
            cold = 1;
            victim = i;
            done = 1;
          end else if (shadow_stamp[k] < oldest) begin
            oldest = shadow_stamp[k];
            victim = i;
          end
        end
      end
      r.way = victim[WAY_OUT_W-1:0];
      if (r.outcome != OUT_HIT) begin
        k = base + victim;
        shadow_valid[k] = 1'b1;
        shadow_tag[k]   = tag[TAG_W-1:0];
        shadow_word[k]  = mem;
        shadow_stamp[k] = n_refs;
        n_misses++;
        if (cold) begin
          n_cold++;
          r.outcome = OUT_COLD;
        end else begin
          n_hot++;
          r.outcome = OUT_HOT;
        end
      end
    end
    r.refs   = n_refs;
    r.hits   = n_hits;
    r.misses = n_misses;
    r.colds  = n_cold;
    r.hots   = n_hot;
    return r;
  endfunction

  // Directed table builders
  function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '{kind: ROW_CFG, reg_index: idx, reg_value: value, addr: '0, word: '0,
            known: 0, result: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void row_lookup(input logic [ADDR_W-1:0] a, input logic [WORD_W-1:0] w);
    stim_row_t row;
    row = '{kind: ROW_LOOKUP, reg_index: CFG_MODE, reg_value: '0, addr: a, word: w,
            known: 0, result: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void row_known(input logic [ADDR_W-1:0] a, input logic [WORD_W-1:0] w,
                                    input logic [WORD_W-1:0] data,
                                    input logic [OUTCOME_W-1:0] oc,
                                    input logic [CNT_W-1:0] refs, hits, misses, colds, hots);
    stim_row_t row;
    lookup_result_t r;
    r = '0;
    r.data = data;
    r.outcome = oc;
    r.refs = refs;
    r.hits = hits;
    r.misses = misses;
    r.colds = colds;
    r.hots = hots;
    row = '{kind: ROW_LOOKUP, reg_index: CFG_MODE, reg_value: '0, addr: a, word: w,
            known: 1, result: r};
    directed_rows.push_back(row);
  endfunction

  // Present one lookup word; the sender idles in bursts with random gaps
  task automatic issue_word(input logic [ADDR_W-1:0] a, input logic [WORD_W-1:0] w,
                            input bit known, input lookup_result_t known_result);
    int gap;
    lookup_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    address     <= a;
    memory_word <= w;
    do @(posedge clk); while (!in_ready);
    r = predict_lookup(a, w);
    if (known) r = known_result;
    lookup_results_due.push_back(r);
    words_sent++;
  endtask

  // Register write, only once every pending result has come back
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODE) cur_mode = value[MODE_W-1:0];
    else if (idx == CFG_SLOTS) cur_slots = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: switches between always ready, coin-flip, and long stall runs
  always @(negedge clk) begin
    if (rx_style_left == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_style_left = $urandom_range(20, 200);
    end
    rx_style_left--;
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_run_left == 0) begin
          rx_stalled = !rx_stalled;
          rx_run_left = rx_stalled ? $urandom_range(1, 8) : $urandom_range(1, 4);
        end
        rx_run_left--;
        out_ready <= !rx_stalled;
      end
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker: each accepted word against the oldest pending prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (lookup_results_due.size() == 0) begin
        $error("result word with no lookup pending");
        mismatches++;
      end else begin
        oldest_due = lookup_results_due.pop_front();
        check_field("read_data", oldest_due.data, read_data);
        check_field("outcome", 32'(oldest_due.outcome), 32'(outcome));
        check_field("way_used", 32'(oldest_due.way), 32'(way_used));
        check_field("reference_count", oldest_due.refs, reference_count);
        check_field("hit_count", oldest_due.hits, hit_count);
        check_field("miss_count", oldest_due.misses, miss_count);
        check_field("cold_miss_count", oldest_due.colds, cold_miss_count);
        check_field("hot_miss_count", oldest_due.hots, hot_miss_count);
      end
    end
  end

  // Watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("word_cache_dm_or_4way_lru verification failed");
      $finish;
    end
  end

  initial begin
    int phase_len, pick, pool_n, slot_pick;
    logic [ADDR_W-1:0] a;
    logic [MODE_W-1:0] next_mode;
    logic [CFG_DATA_W-1:0] next_slots;
    logic [ADDR_W-1:0] addr_pool[$];
    lookup_result_t none;

    rst         = 1'b1;
    in_valid    = 1'b0;
    address     = '0;
    memory_word = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_MODE;
    cfg_data    = '0;
    none        = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      shadow_valid[i] = 0;
      shadow_tag[i]   = '0;
      shadow_word[i]  = '0;
      shadow_stamp[i] = '0;
    end
    n_refs = '0; n_hits = '0; n_misses = '0; n_cold = '0; n_hot = '0;

    // Directed table: reset defaults, extremes, pass-through, set fills and
    // evictions over slots left by direct-mapped mode, odd slot counts
    row_known(32'h0000_0000, 32'hDEAD_BEEF, 32'hDEAD_BEEF, OUT_COLD, 1, 0, 1, 1, 0);
    row_known(32'h0000_0000, 32'h1234_5678, 32'hDEAD_BEEF, OUT_HIT, 2, 1, 1, 1, 0);
    row_known(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OUT_COLD, 3, 1, 2, 2, 0);
    row_known(32'h0000_1000, 32'h0000_0000, 32'h0000_0000, OUT_HOT, 4, 1, 3, 2, 1);
    row_lookup(32'h0000_0003, 32'h0F0F_0F0F);
    row_cfg(CFG_MODE, CFG_DATA_W'(MODE_PASS));
    row_known(32'hFFFF_FFFC, 32'h5A5A_5A5A, 32'h5A5A_5A5A, OUT_PASS, 5, 1, 4, 2, 2);
    row_cfg(CFG_MODE, CFG_DATA_W'(MODE_PASS_ALT));
    row_known(32'h0000_0000, 32'h0000_0001, 32'h0000_0001, OUT_PASS, 5, 1, 4, 2, 2);
    row_cfg(CFG_MODE, CFG_DATA_W'(MODE_SET));
    row_cfg(CFG_SLOTS, 11'd4);
    row_lookup(32'h0000_0010, 32'hAAAA_0001);
    row_lookup(32'h0000_0020, 32'hAAAA_0002);
    row_lookup(32'h0000_0030, 32'hAAAA_0003);
    row_lookup(32'h0000_0000, 32'hAAAA_0004);
    row_lookup(32'h0000_0040, 32'hAAAA_0005);
    row_lookup(32'h0000_0024, 32'hAAAA_0006);
    row_lookup(32'h0000_0020, 32'hAAAA_0007);
    row_cfg(CFG_SLOTS, 11'd0);
    row_lookup(32'hFFFF_FFFF, 32'h8000_0000);
    row_lookup(32'hFFFF_FFFC, 32'h7FFF_FFFF);
    row_cfg(CFG_SLOTS, 11'd2047);
    row_lookup(32'h8000_0000, 32'hFFFF_FFFF);
    row_lookup(32'h7FFF_FFFC, 32'h0000_0000);
    row_cfg(CFG_MODE, CFG_DATA_W'(MODE_DM));
    row_cfg(CFG_SLOTS, 11'd3);
    row_lookup(32'h0000_0004, 32'h1111_1111);
    row_lookup(32'h0000_0008, 32'h2222_2222);
    row_lookup(32'h0000_0004, 32'h3333_3333);
    row_cfg(CFG_SLOTS, 11'd1024);
    row_lookup(32'h0000_1000, 32'h4444_4444);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      else
        issue_word(directed_rows[i].addr, directed_rows[i].word,
                   directed_rows[i].known, directed_rows[i].result);
    end

    // Random phases: new settings, then lookups over a small address pool
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) next_mode = MODE_DM;
      else if (pick < 17) next_mode = MODE_SET;
      else next_mode = $urandom_range(0, 1) ? MODE_PASS : MODE_PASS_ALT;
      slot_pick = $urandom_range(0, 19);
      if (slot_pick < 12) next_slots = CFG_DATA_W'(1 << $urandom_range(2, 6));
      else if (slot_pick < 14) next_slots = 11'd1024;
      else if (slot_pick < 15) next_slots = 11'd2047;
      else if (slot_pick < 16) next_slots = CFG_DATA_W'($urandom_range(0, 3));
      else if (slot_pick < 17) next_slots = CFG_DATA_W'($urandom());
      else next_slots = CFG_DATA_W'(1 << $urandom_range(7, 9));
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        write_register(CFG_MODE, CFG_DATA_W'(next_mode));
        write_register(CFG_SLOTS, next_slots);
      end else if (pick < 7) begin
        write_register(CFG_SLOTS, next_slots);
        write_register(CFG_MODE, CFG_DATA_W'(next_mode));
      end else if (pick < 9) begin
        write_register(CFG_MODE, CFG_DATA_W'(next_mode));
      end else begin
        write_register(CFG_SLOTS, next_slots);
      end

      // pool addresses often share low index bits so sets collide
      addr_pool.delete();
      pool_n = $urandom_range(2, 20);
      repeat (pool_n) begin
        a = $urandom();
        if ($urandom_range(0, 2) != 0) a[11:2] = 10'($urandom_range(0, 15));
        addr_pool.push_back(a);
      end

      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          a = addr_pool[$urandom_range(0, pool_n - 1)];
          if ($urandom_range(0, 3) == 0) a[1:0] = 2'($urandom_range(0, 3));
        end else begin
          a = $urandom();
        end
        issue_word(a, $urandom(), 0, none);
      end
    end

    // Drain and let any stray result word show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("word_cache_dm_or_4way_lru verification clean");
    else
      $display("word_cache_dm_or_4way_lru verification failed");
    $finish;
  end

endmodule
